/* rtl/cscm_pkg.sv */
package cscm_pkg;

   localparam logic [7:0] CharStar    = 8'h2A;
   localparam logic [7:0] CharSlash   = 8'h2F;
   localparam logic [7:0] CharQuote   = 8'h22;
   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharBslash  = 8'h5C;
   localparam logic [7:0] CharSpace   = 8'h20;

   localparam int QueueDepth = 4;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_LINE   = 2'd1,
      MODE_BLOCK  = 2'd2,
      MODE_STRING = 2'd3
   } lexer_mode_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_line_end;
      logic       run_last;
   } result_type;

   // up to two result words caused by one input word
   typedef struct packed {
      logic [1:0]       count;
      result_type [1:0] item;
   } burst_type;

endpackage

/* rtl/cscm_lexer.sv */
module cscm_lexer (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_char,
   input  logic               line_end,
   output cscm_pkg::burst_type burst
);
   import cscm_pkg::*;

   lexer_mode_type mode_ff, mode_in;
   logic [7:0]     pending_char_ff, pending_char_in;
   logic           pending_valid_ff, pending_valid_in;
   logic           keep_next_ff, keep_next_in;
   logic           prev_backslash_ff, prev_backslash_in;

   logic [7:0] decided;
   logic [7:0] cur_char;
   logic       blank;

   always_comb begin
      mode_in           = mode_ff;
      keep_next_in      = keep_next_ff;
      prev_backslash_in = prev_backslash_ff;
      decided           = pending_char_ff;
      blank             = 1'b0;

      // fate of the held byte, given the incoming byte as lookahead
      if (pending_valid_ff) begin
         if (keep_next_ff) begin
            keep_next_in = 1'b0;
         end else begin
            unique case (mode_ff)
               MODE_LINE: begin
                  decided = CharSpace;
               end
               MODE_BLOCK: begin
                  decided = CharSpace;
                  if (pending_char_ff == CharStar && in_char == CharSlash) begin
                     blank   = 1'b1;
                     mode_in = MODE_NORMAL;
                  end
               end
               MODE_STRING: begin
                  priority if (pending_char_ff == CharQuote) begin
                     mode_in = MODE_NORMAL;
                  end else if (pending_char_ff == CharPercent ||
                               pending_char_ff == CharBslash) begin
                     keep_next_in = 1'b1;
                  end else begin
                     decided = CharSpace;
                  end
               end
               MODE_NORMAL: begin
                  priority if (pending_char_ff == CharSlash && in_char == CharStar) begin
                     decided = CharSpace;
                     mode_in = MODE_BLOCK;
                  end else if (pending_char_ff == CharSlash && in_char == CharSlash) begin
                     decided = CharSpace;
                     mode_in = MODE_LINE;
                  end else if (pending_char_ff == CharQuote && !prev_backslash_ff) begin
                     mode_in = MODE_STRING;
                  end else begin
                  end
               end
               default: begin
               end
            endcase
         end
         prev_backslash_in = (decided == CharBslash);
      end

      cur_char = blank ? CharSpace : in_char;

      pending_char_in  = pending_char_ff;
      pending_valid_in = pending_valid_ff;
      if (line_end) begin
         pending_valid_in  = 1'b0;
         keep_next_in      = 1'b0;
         prev_backslash_in = 1'b0;
         if (mode_in == MODE_LINE) begin
            mode_in = MODE_NORMAL;
         end
      end else begin
         pending_char_in  = cur_char;
         pending_valid_in = 1'b1;
      end

      burst.count = {1'b0, pending_valid_ff} + {1'b0, line_end};
      if (pending_valid_ff) begin
         burst.item[0] = '{out_char: decided, out_line_end: 1'b0, run_last: !line_end};
      end else begin
         burst.item[0] = '{out_char: cur_char, out_line_end: 1'b1, run_last: 1'b1};
      end
      burst.item[1] = '{out_char: cur_char, out_line_end: 1'b1, run_last: 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_NORMAL;
         pending_char_ff   <= 8'h00;
         pending_valid_ff  <= 1'b0;
         keep_next_ff      <= 1'b0;
         prev_backslash_ff <= 1'b0;
      end else if (accept) begin
         mode_ff           <= mode_in;
         pending_char_ff   <= pending_char_in;
         pending_valid_ff  <= pending_valid_in;
         keep_next_ff      <= keep_next_in;
         prev_backslash_ff <= prev_backslash_in;
      end
   end

endmodule

/* rtl/cscm_out_queue.sv */
module cscm_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  cscm_pkg::burst_type  burst,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cscm_pkg::result_type head
);
   import cscm_pkg::*;

   result_type q_ff [QueueDepth];
   result_type q_in [QueueDepth];
   result_type shifted [QueueDepth];
   logic [2:0] count_ff, count_in;
   logic [2:0] kept;
   logic       pop;

   assign rsp_valid = (count_ff != 3'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign room      = (count_ff <= 3'(QueueDepth - 2));
   assign head      = q_ff[0];
   assign kept      = count_ff - {2'b00, pop};

   always_comb begin
      for (int i = 0; i < QueueDepth; i++) begin
         if (pop && i < QueueDepth - 1) begin
            shifted[i] = q_ff[i + 1];
         end else begin
            shifted[i] = q_ff[i];
         end
      end
      for (int i = 0; i < QueueDepth; i++) begin
         priority if (3'(i) < kept) begin
            q_in[i] = shifted[i];
         end else if (3'(i) == kept) begin
            q_in[i] = burst.item[0];
         end else begin
            q_in[i] = burst.item[1];
         end
      end
      count_in = accept ? kept + {1'b0, burst.count} : kept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QueueDepth; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

/* rtl/c_comment_string_masker.sv */
// channel  | valid / ready          | payload
// ---------+------------------------+------------------------------------------
// req      | req_valid / req_ready  | req_in_char, req_line_end
// rsp      | rsp_valid / rsp_ready  | rsp_out_char, rsp_out_line_end, rsp_run_last
//
// one word accepted per cycle while req_ready is high; its results sit in a four-word
// output queue and show on rsp in order, one word per cycle while rsp_ready is high
// a word that ends a line after a held byte makes two results, but the word after it
// makes at most one, so with rsp_ready high the queue holds at most two and input never waits
// req_ready is high while the queue holds at most two words, with no path from rsp_ready
// synchronous active-high reset clears lexer mode, held byte and queue count
module c_comment_string_masker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_line_end,
   output logic       rsp_run_last
);
   import cscm_pkg::*;

   burst_type  burst;
   result_type head;
   logic       accept;

   assign accept = req_valid && req_ready;

   cscm_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_char  (req_in_char),
      .line_end (req_line_end),
      .burst    (burst)
   );

   cscm_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .burst     (burst),
      .room      (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_out_char     = head.out_char;
   assign rsp_out_line_end = head.out_line_end;
   assign rsp_run_last     = head.run_last;

endmodule

/* dv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cscm_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int RandomWords = 900;
   localparam int DrainCycles = 10;
   localparam int LongHold    = 200;

   typedef struct packed {
      logic [7:0] ch;
      logic       le;
      logic       typed;
      logic [1:0] n;
      logic [7:0] c0;
      logic [7:0] c1;
   } stim_row_t;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_char;
   logic       req_line_end;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_char;
   logic       rsp_out_line_end;
   logic       rsp_run_last;

   // expectation carried alongside the payload of a table row
   logic       row_typed;
   logic [1:0] row_n;
   logic [7:0] row_c0;
   logic [7:0] row_c1;

   int snd_idle_pct;
   int rsp_idle_pct;
   int rsp_hold;
   int cycles;
   int errors;
   int words_in;
   int results_out;

   // masker state mirror
   lexer_mode_type mode;
   logic [7:0]     held_char;
   logic           held_valid;
   logic           blank_slash;
   logic           keep_byte;
   logic           after_bslash;
   logic [3:0]     modes_seen;
   result_type     step_res [2];
   result_type     masked_q [$];

   stim_row_t directed_rows [25] = '{
      '{"a",         1'b1, 1'b1, 2'd1, "a",   8'h00},
      '{8'hFF,       1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
      '{8'h00,       1'b1, 1'b1, 2'd2, 8'hFF, 8'h00},
      // slash star slash is a whole comment
      '{CharSlash,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharStar,    1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharSlash,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{"x",         1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
      // line comment
      '{CharSlash,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharSlash,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{"q",         1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
      // block comment across lines, closed at line end
      '{CharSlash,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharStar,    1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharStar,    1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharSlash,   1'b1, 1'b0, 2'd0, 8'h00, 8'h00},
      // string with escaped quote, percent, escaped backslash, then escaped quote outside
      '{CharQuote,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharBslash,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharQuote,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharPercent, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{"d",         1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharBslash,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharBslash,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharQuote,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharBslash,  1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{CharQuote,   1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
      '{"z",         1'b1, 1'b0, 2'd0, 8'h00, 8'h00}
   };

   c_comment_string_masker dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_in_char,
      .req_line_end,
      .rsp_valid,
      .rsp_ready,
      .rsp_out_char,
      .rsp_out_line_end,
      .rsp_run_last
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [7:0] mask_decide(input logic [7:0] held, input logic [7:0] look);
      logic [7:0] o;
      o = held;
      if (keep_byte) begin
         keep_byte = 1'b0;
         return o;
      end
      case (mode)
         MODE_LINE: begin
            o = CharSpace;
         end
         MODE_BLOCK: begin
            if (held == CharStar && look == CharSlash) begin
               blank_slash = 1'b1;
               mode = MODE_NORMAL;
            end
            o = CharSpace;
         end
         MODE_STRING: begin
            if (held == CharQuote) begin
               mode = MODE_NORMAL;
            end else if (held == CharPercent || held == CharBslash) begin
               keep_byte = 1'b1;
            end else begin
               o = CharSpace;
            end
         end
         default: begin
            if (held == CharSlash && look == CharStar) begin
               o = CharSpace;
               mode = MODE_BLOCK;
            end else if (held == CharSlash && look == CharSlash) begin
               o = CharSpace;
               mode = MODE_LINE;
            end else if (held == CharQuote && !after_bslash) begin
               mode = MODE_STRING;
            end
         end
      endcase
      return o;
   endfunction

   function automatic int mask_step(input logic [7:0] ch, input logic le);
      int n;
      logic [7:0] c;
      n = 0;
      c = ch;
      if (held_valid) begin
         step_res[0].out_char = mask_decide(held_char, ch);
         step_res[0].out_line_end = 1'b0;
         step_res[0].run_last = 1'b0;
         after_bslash = (step_res[0].out_char == CharBslash);
         held_valid = 1'b0;
         n = 1;
      end
      if (blank_slash) begin
         c = CharSpace;
         blank_slash = 1'b0;
      end
      if (le) begin
         step_res[n].out_char = c;
         step_res[n].out_line_end = 1'b1;
         step_res[n].run_last = 1'b0;
         n++;
         keep_byte = 1'b0;
         after_bslash = 1'b0;
         if (mode == MODE_LINE) begin
            mode = MODE_NORMAL;
         end
      end else begin
         held_char = c;
         held_valid = 1'b1;
      end
      if (n > 0) begin
         step_res[n - 1].run_last = 1'b1;
      end
      modes_seen[mode] = 1'b1;
      return n;
   endfunction

   function automatic stim_row_t random_word();
      stim_row_t r;
      int pick;
      r = '0;
      pick = $urandom_range(99);
      if (pick < 12) begin
         r.ch = CharSlash;
      end else if (pick < 22) begin
         r.ch = CharStar;
      end else if (pick < 32) begin
         r.ch = CharQuote;
      end else if (pick < 39) begin
         r.ch = CharBslash;
      end else if (pick < 44) begin
         r.ch = CharPercent;
      end else if (pick < 52) begin
         r.ch = CharSpace;
      end else if (pick < 82) begin
         r.ch = 8'($urandom_range(8'h7E, 8'h21));
      end else begin
         r.ch = 8'($urandom);
      end
      r.le = ($urandom_range(5) == 0);
      return r;
   endfunction

   task automatic send_word(input stim_row_t r);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_char <= r.ch;
      req_line_end <= r.le;
      row_typed <= r.typed;
      row_n <= r.n;
      row_c0 <= r.c0;
      row_c1 <= r.c1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // receiver, with a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      int n;
      result_type got;
      result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            n = mask_step(req_in_char, req_line_end);
            words_in++;
            if (row_typed) begin
               for (int k = 0; k < row_n; k++) begin
                  want.out_char = (k == 0) ? row_c0 : row_c1;
                  want.out_line_end = (k == row_n - 1) ? req_line_end : 1'b0;
                  want.run_last = (k == row_n - 1);
                  masked_q.push_back(want);
               end
            end else begin
               for (int k = 0; k < n; k++) begin
                  masked_q.push_back(step_res[k]);
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.out_char = rsp_out_char;
            got.out_line_end = rsp_out_line_end;
            got.run_last = rsp_run_last;
            results_out++;
            if (masked_q.size() == 0) begin
               $error("unexpected word: out_char %h out_line_end %b run_last %b",
                      got.out_char, got.out_line_end, got.run_last);
               errors++;
            end else begin
               want = masked_q.pop_front();
               if (got.out_char !== want.out_char) begin
                  $error("out_char expected %h actual %h", want.out_char, got.out_char);
                  errors++;
               end
               if (got.out_line_end !== want.out_line_end) begin
                  $error("out_line_end expected %b actual %b",
                         want.out_line_end, got.out_line_end);
                  errors++;
               end
               if (got.run_last !== want.run_last) begin
                  $error("run_last expected %b actual %b", want.run_last, got.run_last);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d words still expected", cycles, masked_q.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      stim_row_t row;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_char = 8'h00;
      req_line_end = 1'b0;
      row_typed = 1'b0;
      row_n = 2'd0;
      row_c0 = 8'h00;
      row_c1 = 8'h00;
      snd_idle_pct = 37;
      rsp_idle_pct = 83;
      rsp_hold = 0;
      cycles = 0;
      errors = 0;
      words_in = 0;
      results_out = 0;
      mode = MODE_NORMAL;
      held_char = 8'h00;
      held_valid = 1'b0;
      blank_slash = 1'b0;
      keep_byte = 1'b0;
      after_bslash = 1'b0;
      modes_seen = 4'b0000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_word(directed_rows[i]);
      end
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            snd_idle_pct = 83;
            rsp_idle_pct = 37;
         end else if (phase == 2) begin
            snd_idle_pct = 0;
            rsp_idle_pct = 0;
            rsp_hold = LongHold;
         end
         repeat (RandomWords / 3) begin
            row = random_word();
            send_word(row);
         end
      end
      req_valid <= 1'b0;
      while (masked_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      $display("%0d words sent, %0d result words checked, lexer modes reached %b",
               words_in, results_out, modes_seen);
      $display("idle mixes 37/83, 83/37 and none, plus a %0d cycle output hold-off", LongHold);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
